// File: rtl/fst_pkg.sv
`default_nettype none
package fst_pkg;

  localparam int unsigned MaxProcs = 16;
  localparam int unsigned IdxW     = $clog2(MaxProcs);
  localparam int unsigned CntW     = IdxW + 1;
  localparam int unsigned TimeW    = 16;
  localparam int unsigned CompW    = 21;
  localparam int unsigned SumW     = 25;
  localparam int unsigned KeyW     = TimeW + IdxW;

  typedef struct packed {
    logic [7:0]       proc_id;
    logic [TimeW-1:0] arrival;
    logic [TimeW-1:0] burst;
    logic             last_proc;
  } in_t;

  typedef struct packed {
    logic [7:0]       out_id;
    logic [TimeW-1:0] out_arrival;
    logic [TimeW-1:0] out_burst;
    logic [CompW-1:0] completion;
    logic [CompW-1:0] turnaround;
    logic [CompW-1:0] waiting;
    logic [CompW-1:0] response;
    logic [SumW-1:0]  sum_turnaround;
    logic [SumW-1:0]  sum_waiting;
    logic [TimeW-1:0] idle_total;
    logic [4:0]       proc_count;
    logic             last_row;
  } out_t;

  typedef struct packed {
    logic [7:0]       id;
    logic [TimeW-1:0] arr;
    logic [TimeW-1:0] bur;
  } proc_t;

  typedef struct packed {
    logic             pwe;
    logic [IdxW-1:0]  pwaddr;
    proc_t            pwdata;
    logic [IdxW-1:0]  praddr;
    logic             cwe;
    logic [IdxW-1:0]  cwaddr;
    logic [CompW-1:0] cwdata;
    logic [IdxW-1:0]  craddr;
  } tbl_req_t;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_SSCAN,
    ST_START,
    ST_FINISH,
    ST_ESCAN,
    ST_EREAD,
    ST_EOUT
  } state_e;

endpackage
`default_nettype wire

// File: rtl/fst_table.sv
`default_nettype none
module fst_table (
  input  wire logic                        clk_i,
  input  wire fst_pkg::tbl_req_t           req_i,
  output fst_pkg::proc_t                   prd_o,
  output logic [fst_pkg::CompW-1:0]        crd_o
);

  fst_pkg::proc_t            proc_mem [fst_pkg::MaxProcs];
  logic [fst_pkg::CompW-1:0] comp_mem [fst_pkg::MaxProcs];

  always_ff @(posedge clk_i) begin
    if (req_i.pwe) begin
      proc_mem[req_i.pwaddr] <= req_i.pwdata;
    end
    prd_o <= proc_mem[req_i.praddr];
  end

  always_ff @(posedge clk_i) begin
    if (req_i.cwe) begin
      comp_mem[req_i.cwaddr] <= req_i.cwdata;
    end
    crd_o <= comp_mem[req_i.craddr];
  end

endmodule
`default_nettype wire

// File: rtl/fcfs_schedule_timing.sv
`default_nettype none
// Channel   Direction  Handshake                 Payload
// load      in         start_i high, busy_o low  in_i   (fst_pkg::in_t)
// result    out        res_strobe_o, one cycle   res_o  (fst_pkg::out_t)
//
// A load without last_proc stays in the load state. A load with last_proc starts the set:
// scheduling and emission each pick entries by a full scan of the process table
// (one entry read per cycle), one full scan for every process picked.
// busy_o stays high from the final load until the last result row has gone.
// Reset clears the control state and counters; the tables need no clearing.
// Results cannot be held off: each row appears for exactly one cycle.
module fcfs_schedule_timing (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           start_i,
  input  wire fst_pkg::in_t   in_i,
  output logic                busy_o,
  output logic                res_strobe_o,
  output fst_pkg::out_t       res_o
);

  localparam int unsigned IdxW = fst_pkg::IdxW;
  localparam int unsigned CntW = fst_pkg::CntW;
  localparam int unsigned KeyW = fst_pkg::KeyW;

  fst_pkg::state_e  state_q, state_d;
  fst_pkg::tbl_req_t req;
  fst_pkg::proc_t   prd;
  logic [fst_pkg::CompW-1:0] crd;

  logic [CntW-1:0] cnt_q, sc_q, k_q;
  logic            rd_vld_q, have_last_q, found_q;
  logic [IdxW-1:0] rd_idx_q, best_idx_q;
  logic [KeyW-1:0] best_key_q, last_key_q, rd_key;
  fst_pkg::proc_t  best_q;
  logic [fst_pkg::CompW-1:0] ct_q, start_q, wait_q;
  logic [fst_pkg::SumW-1:0]  tsum_q, wsum_q;
  logic [fst_pkg::TimeW-1:0] idle_q;

  logic accept, scanning, scan_done, take;
  logic [fst_pkg::CompW-1:0] arr_ext, ct_new, t_val, w_val;

  fst_table u_table (
    .clk_i (clk_i),
    .req_i (req),
    .prd_o (prd),
    .crd_o (crd)
  );

  assign accept    = start_i && !busy_o;
  assign scanning  = (state_q == fst_pkg::ST_SSCAN) || (state_q == fst_pkg::ST_ESCAN);
  assign scan_done = rd_vld_q && ({1'b0, rd_idx_q} == cnt_q - CntW'(1));
  assign arr_ext   = fst_pkg::CompW'(best_q.arr);

  always_comb begin
    if (state_q == fst_pkg::ST_SSCAN) begin
      rd_key = {prd.arr, rd_idx_q};
    end else begin
      rd_key = {KeyW'(prd.id) << IdxW} | KeyW'(rd_idx_q);
    end
  end

  // An entry qualifies when its key lies above the last one taken; keys are unique
  // because the index sits in the low bits, so ties keep load order.
  assign take = rd_vld_q && (!have_last_q || rd_key > last_key_q) &&
                (!found_q || rd_key < best_key_q);

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      fst_pkg::ST_LOAD: begin
        if (accept && in_i.last_proc) state_d = fst_pkg::ST_SSCAN;
      end
      fst_pkg::ST_SSCAN: begin
        if (scan_done) state_d = fst_pkg::ST_START;
      end
      fst_pkg::ST_START:  state_d = fst_pkg::ST_FINISH;
      fst_pkg::ST_FINISH: begin
        state_d = (k_q == cnt_q - CntW'(1)) ? fst_pkg::ST_ESCAN : fst_pkg::ST_SSCAN;
      end
      fst_pkg::ST_ESCAN: begin
        if (scan_done) state_d = fst_pkg::ST_EREAD;
      end
      fst_pkg::ST_EREAD:  state_d = fst_pkg::ST_EOUT;
      fst_pkg::ST_EOUT: begin
        state_d = (k_q == cnt_q - CntW'(1)) ? fst_pkg::ST_LOAD : fst_pkg::ST_ESCAN;
      end
      default: state_d = fst_pkg::ST_LOAD;
    endcase
  end

  // Outputs and table requests
  always_comb begin
    busy_o           = (state_q != fst_pkg::ST_LOAD);
    res_strobe_o     = (state_q == fst_pkg::ST_EOUT);
    req.pwe          = accept && (cnt_q < CntW'(fst_pkg::MaxProcs));
    req.pwaddr       = cnt_q[IdxW-1:0];
    req.pwdata.id    = in_i.proc_id;
    req.pwdata.arr   = in_i.arrival;
    req.pwdata.bur   = in_i.burst;
    req.praddr       = sc_q[IdxW-1:0];
    req.cwe          = (state_q == fst_pkg::ST_FINISH);
    req.cwaddr       = best_idx_q;
    req.cwdata       = ct_new;
    req.craddr       = best_idx_q;
  end

  assign ct_new = start_q + fst_pkg::CompW'(best_q.bur);
  assign t_val  = crd - arr_ext;
  assign w_val  = t_val - fst_pkg::CompW'(best_q.bur);

  always_comb begin
    res_o.out_id         = best_q.id;
    res_o.out_arrival    = best_q.arr;
    res_o.out_burst      = best_q.bur;
    res_o.completion     = crd;
    res_o.turnaround     = t_val;
    res_o.waiting        = w_val;
    res_o.response       = w_val;
    res_o.sum_turnaround = tsum_q;
    res_o.sum_waiting    = wsum_q;
    res_o.idle_total     = idle_q;
    res_o.proc_count     = 5'(cnt_q);
    res_o.last_row       = (k_q == cnt_q - CntW'(1));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= fst_pkg::ST_LOAD;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      sc_q        <= '0;
      k_q         <= '0;
      rd_vld_q    <= 1'b0;
      have_last_q <= 1'b0;
      found_q     <= 1'b0;
      ct_q        <= '0;
      tsum_q      <= '0;
      wsum_q      <= '0;
      idle_q      <= '0;
    end else begin
      rd_vld_q <= scanning && (sc_q < cnt_q);
      if (scanning && (sc_q < cnt_q)) sc_q <= sc_q + CntW'(1);
      if (take) found_q <= 1'b1;
      case (state_q)
        fst_pkg::ST_LOAD: begin
          if (req.pwe) cnt_q <= cnt_q + CntW'(1);
          sc_q        <= '0;
          k_q         <= '0;
          found_q     <= 1'b0;
          have_last_q <= 1'b0;
          ct_q        <= '0;
          tsum_q      <= '0;
          wsum_q      <= '0;
          idle_q      <= '0;
        end
        fst_pkg::ST_START: begin
          if (ct_q < arr_ext) begin
            idle_q <= idle_q + best_q.arr - ct_q[fst_pkg::TimeW-1:0];
          end
          have_last_q <= 1'b1;
        end
        fst_pkg::ST_FINISH: begin
          ct_q    <= ct_new;
          tsum_q  <= tsum_q + fst_pkg::SumW'(wait_q) + fst_pkg::SumW'(best_q.bur);
          wsum_q  <= wsum_q + fst_pkg::SumW'(wait_q);
          sc_q    <= '0;
          found_q <= 1'b0;
          if (k_q == cnt_q - CntW'(1)) begin
            k_q         <= '0;
            have_last_q <= 1'b0;
          end else begin
            k_q <= k_q + CntW'(1);
          end
        end
        fst_pkg::ST_EREAD: begin
          have_last_q <= 1'b1;
        end
        fst_pkg::ST_EOUT: begin
          sc_q    <= '0;
          found_q <= 1'b0;
          if (k_q == cnt_q - CntW'(1)) begin
            cnt_q <= '0;
          end else begin
            k_q <= k_q + CntW'(1);
          end
        end
        default: ;
      endcase
    end
  end

  // Datapath registers without reset
  always_ff @(posedge clk_i) begin
    rd_idx_q <= sc_q[IdxW-1:0];
    if (take) begin
      best_key_q <= rd_key;
      best_idx_q <= rd_idx_q;
      best_q     <= prd;
    end
    if ((state_q == fst_pkg::ST_START) || (state_q == fst_pkg::ST_EREAD)) begin
      last_key_q <= best_key_q;
    end
    if (state_q == fst_pkg::ST_START) begin
      if (ct_q < arr_ext) begin
        start_q <= arr_ext;
        wait_q  <= '0;
      end else begin
        start_q <= ct_q;
        wait_q  <= ct_q - arr_ext;
      end
    end
  end

endmodule
`default_nettype wire
